// ===== rtl/core/kbpc_pkg.sv =====
// Shared types, constants and the exponential table for the KDE pixel classifier.
// Used by kbpc_ctrl, kbpc_dp and kde_background_pixel_classifier; no dependencies.
`timescale 1ns / 1ps

package kbpc_pkg;

    // fixed-point format
    localparam int FRAC_BITS   = 12;
    localparam int ONE_Q       = 1 << FRAC_BITS;
    localparam int DOWN_SHIFT  = 16 - FRAC_BITS;
    localparam int PIX_W       = 8;
    localparam int INV_W       = 16;
    localparam int DIFF_MUL_W  = PIX_W + INV_W;
    localparam int U_W         = DIFF_MUL_W - DOWN_SHIFT + 1;
    localparam int SQ_W        = 2 * U_W;
    localparam int S_W         = SQ_W + 2;
    localparam int T_W         = SQ_W - FRAC_BITS + 1;
    localparam int ACC_W       = 48;
    localparam int COEF_W      = 32;
    localparam int COEF_SHIFT  = 32;

    // shared magnitude multiplier, operand a taken in two halves
    localparam int MUL_A_W     = ACC_W;
    localparam int MUL_B_W     = 32;
    localparam int HALF_A_W    = MUL_A_W / 2;
    localparam int PART_W      = HALF_A_W + MUL_B_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    // exponential table
    localparam int EXP_ENTRIES = 256;
    localparam int IDX_W       = $clog2(EXP_ENTRIES);
    localparam int ROM_W       = FRAC_BITS + 1;
    localparam int G_SHIFT     = 2 * FRAC_BITS + 5 - IDX_W;
    localparam int SER_Q       = 59;
    localparam int SER_TERMS   = 40;

    // saturation limits of the accumulator
    localparam logic [ACC_W-1:0] POS_LIM = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] NEG_LIM = {1'b1, {(ACC_W-1){1'b0}}};

    // configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = ACC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_SELECT       = 2'd0,
        CFG_INV_BANDWIDTH       = 2'd1,
        CFG_DENSITY_COEFFICIENT = 2'd2,
        CFG_DENSITY_THRESHOLD   = 2'd3
    } t_cfg_idx;

    localparam logic             KSEL_RST  = 1'b1;
    localparam logic [INV_W-1:0] INV_RST   = 16'd2185;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ0_LO,
        ST_SQ0_HI,
        ST_SQ1_LO,
        ST_SQ1_HI,
        ST_SQ2_LO,
        ST_SQ2_HI,
        ST_SQ_DONE,
        ST_EP01_LO,
        ST_EP01_HI,
        ST_EP01_FIN,
        ST_EP2_LO,
        ST_EP2_HI,
        ST_EP2_FIN,
        ST_GAUSS,
        ST_ACC,
        ST_SUM_ABS,
        ST_DENS_LO,
        ST_DENS_HI,
        ST_DENS_FIN,
        ST_OUT
    } t_state;

    // operand pairs for the shared multiplier
    typedef enum logic [2:0] {
        MOP_SQ0,
        MOP_SQ1,
        MOP_SQ2,
        MOP_EP01,
        MOP_EP2,
        MOP_DENS
    } t_mul_op;

    // what the datapath captures in a cycle
    typedef enum logic [3:0] {
        CM_NONE,
        CM_SQ0,
        CM_SQ1,
        CM_SQ2,
        CM_K01,
        CM_KER,
        CM_GAUSS,
        CM_ACC,
        CM_SABS,
        CM_DENS
    } t_commit;

    typedef struct packed {
        logic    accept;
        logic    mul_en;
        logic    mul_hi;
        t_mul_op mul_op;
        t_commit commit;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic ksel;
        logic out_free;
    } t_dp_status;

    typedef logic [EXP_ENTRIES-1:0][ROM_W-1:0] t_exp_rom;

    // unsigned quotient by shift and subtract, only used while building the table
    function automatic logic [63:0] f_udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-i*16/EXP_ENTRIES) per entry, built from successive Q59 powers of the step
    function automatic t_exp_rom f_build_exp_rom();
        t_exp_rom     rom;
        logic [63:0]  term;
        logic [63:0]  step;
        logic [63:0]  e;
        logic [127:0] p;
        logic [63:0]  ent;
        term = 64'd1 << SER_Q;
        step = term;
        e    = term;
        for (int n = 1; n <= SER_TERMS; n++) begin
            term = f_udiv64(term * 64'd16, 64'(EXP_ENTRIES) * 64'(n));
            if (n[0]) begin
                step = step - term;
            end else begin
                step = step + term;
            end
        end
        rom[0] = ROM_W'(ONE_Q);
        for (int i = 1; i < EXP_ENTRIES; i++) begin
            p      = {64'd0, e} * {64'd0, step};
            e      = 64'(p >> SER_Q) + 64'(p[SER_Q-1]);
            ent    = (e >> (SER_Q - FRAC_BITS)) + 64'(e[SER_Q-FRAC_BITS-1]);
            rom[i] = ent[ROM_W-1:0];
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = f_build_exp_rom();

endpackage

// ===== rtl/core/kbpc_ctrl.sv =====
// Sequencer of the KDE pixel classifier: steps the datapath through one request.
// Depends on kbpc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module kbpc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  kbpc_pkg::t_dp_status i_status,
    output kbpc_pkg::t_dp_cmd   o_cmd
);

    kbpc_pkg::t_state r_state;
    kbpc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kbpc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kbpc_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = kbpc_pkg::ST_SQ0_LO;
                end
            end
            kbpc_pkg::ST_SQ0_LO:   n_state = kbpc_pkg::ST_SQ0_HI;
            kbpc_pkg::ST_SQ0_HI:   n_state = kbpc_pkg::ST_SQ1_LO;
            kbpc_pkg::ST_SQ1_LO:   n_state = kbpc_pkg::ST_SQ1_HI;
            kbpc_pkg::ST_SQ1_HI:   n_state = kbpc_pkg::ST_SQ2_LO;
            kbpc_pkg::ST_SQ2_LO:   n_state = kbpc_pkg::ST_SQ2_HI;
            kbpc_pkg::ST_SQ2_HI:   n_state = kbpc_pkg::ST_SQ_DONE;
            kbpc_pkg::ST_SQ_DONE: begin
                n_state = i_status.ksel ? kbpc_pkg::ST_EP01_LO : kbpc_pkg::ST_GAUSS;
            end
            kbpc_pkg::ST_EP01_LO:  n_state = kbpc_pkg::ST_EP01_HI;
            kbpc_pkg::ST_EP01_HI:  n_state = kbpc_pkg::ST_EP01_FIN;
            kbpc_pkg::ST_EP01_FIN: n_state = kbpc_pkg::ST_EP2_LO;
            kbpc_pkg::ST_EP2_LO:   n_state = kbpc_pkg::ST_EP2_HI;
            kbpc_pkg::ST_EP2_HI:   n_state = kbpc_pkg::ST_EP2_FIN;
            kbpc_pkg::ST_EP2_FIN:  n_state = kbpc_pkg::ST_ACC;
            kbpc_pkg::ST_GAUSS:    n_state = kbpc_pkg::ST_ACC;
            kbpc_pkg::ST_ACC: begin
                n_state = i_status.last ? kbpc_pkg::ST_SUM_ABS : kbpc_pkg::ST_IDLE;
            end
            kbpc_pkg::ST_SUM_ABS:  n_state = kbpc_pkg::ST_DENS_LO;
            kbpc_pkg::ST_DENS_LO:  n_state = kbpc_pkg::ST_DENS_HI;
            kbpc_pkg::ST_DENS_HI:  n_state = kbpc_pkg::ST_DENS_FIN;
            kbpc_pkg::ST_DENS_FIN: n_state = kbpc_pkg::ST_OUT;
            kbpc_pkg::ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = kbpc_pkg::ST_IDLE;
                end
            end
            default:               n_state = kbpc_pkg::ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.mul_en    = 1'b0;
        o_cmd.mul_hi    = 1'b0;
        o_cmd.mul_op    = kbpc_pkg::MOP_SQ0;
        o_cmd.commit    = kbpc_pkg::CM_NONE;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            kbpc_pkg::ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            kbpc_pkg::ST_SQ0_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_SQ0;
            end
            kbpc_pkg::ST_SQ0_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_SQ0;
            end
            kbpc_pkg::ST_SQ1_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_SQ1;
                o_cmd.commit = kbpc_pkg::CM_SQ0;
            end
            kbpc_pkg::ST_SQ1_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_SQ1;
            end
            kbpc_pkg::ST_SQ2_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_SQ2;
                o_cmd.commit = kbpc_pkg::CM_SQ1;
            end
            kbpc_pkg::ST_SQ2_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_SQ2;
            end
            kbpc_pkg::ST_SQ_DONE: begin
                o_cmd.commit = kbpc_pkg::CM_SQ2;
            end
            kbpc_pkg::ST_EP01_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_EP01;
            end
            kbpc_pkg::ST_EP01_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_EP01;
            end
            kbpc_pkg::ST_EP01_FIN: begin
                o_cmd.commit = kbpc_pkg::CM_K01;
            end
            kbpc_pkg::ST_EP2_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_EP2;
            end
            kbpc_pkg::ST_EP2_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_EP2;
            end
            kbpc_pkg::ST_EP2_FIN: begin
                o_cmd.commit = kbpc_pkg::CM_KER;
            end
            kbpc_pkg::ST_GAUSS: begin
                o_cmd.commit = kbpc_pkg::CM_GAUSS;
            end
            kbpc_pkg::ST_ACC: begin
                o_cmd.commit = kbpc_pkg::CM_ACC;
            end
            kbpc_pkg::ST_SUM_ABS: begin
                o_cmd.commit = kbpc_pkg::CM_SABS;
            end
            kbpc_pkg::ST_DENS_LO: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_DENS;
            end
            kbpc_pkg::ST_DENS_HI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.mul_op = kbpc_pkg::MOP_DENS;
            end
            kbpc_pkg::ST_DENS_FIN: begin
                o_cmd.commit = kbpc_pkg::CM_DENS;
            end
            kbpc_pkg::ST_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // a result is only loaded into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_status.out_free)
        else $error("result loaded while output register occupied");

    // an accepted request starts the first square at once
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (o_cmd.mul_en && !o_cmd.mul_hi && o_cmd.mul_op == kbpc_pkg::MOP_SQ0))
        else $error("accepted request did not start the multiplier");

endmodule

// ===== rtl/core/kbpc_dp.sv =====
// Datapath of the KDE pixel classifier: channel offsets, shared multiplier,
// rounding and saturation, kernel accumulator and output register. Uses kbpc_pkg.
`timescale 1ns / 1ps

module kbpc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kbpc_pkg::t_dp_cmd                 i_cmd,
    output kbpc_pkg::t_dp_status              o_status,
    input  logic [6*kbpc_pkg::PIX_W-1:0]      i_s_tdata,
    input  logic                              i_s_tlast,
    input  logic                              i_ksel,
    input  logic [kbpc_pkg::INV_W-1:0]        i_inv_bw,
    input  logic [kbpc_pkg::COEF_W-1:0]       i_coef,
    input  logic signed [kbpc_pkg::ACC_W-1:0] i_thr,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [kbpc_pkg::ACC_W-1:0]        o_m_density,
    output logic                              o_m_foreground
);

    localparam int NCH = 3;

    logic [kbpc_pkg::U_W-1:0]     r_u [NCH];
    logic [kbpc_pkg::T_W-1:0]     r_tmag [NCH];
    logic                         r_tneg [NCH];
    logic [kbpc_pkg::MUL_A_W-1:0] r_kmag;
    logic                         r_kneg;
    logic [kbpc_pkg::ACC_W-1:0]   r_kval;
    logic [kbpc_pkg::S_W-1:0]     r_s;
    logic [kbpc_pkg::PROD_W-1:0]  r_prod;
    logic [kbpc_pkg::ACC_W-1:0]   r_sum;
    logic [kbpc_pkg::ACC_W-1:0]   r_dens;
    logic                         r_last;
    logic                         r_ksel;
    logic                         r_out_valid;
    logic [kbpc_pkg::ACC_W-1:0]   r_out_density;
    logic                         r_out_fg;

    logic [kbpc_pkg::U_W-1:0]     n_u [NCH];

    // per-channel scaled distance, rounded half up on the magnitude
    always_comb begin
        logic [kbpc_pkg::PIX_W-1:0]      v_test;
        logic [kbpc_pkg::PIX_W-1:0]      v_train;
        logic [kbpc_pkg::PIX_W-1:0]      v_diff;
        logic [kbpc_pkg::DIFF_MUL_W-1:0] v_m;
        for (int c = 0; c < NCH; c++) begin
            v_test  = i_s_tdata[c*kbpc_pkg::PIX_W +: kbpc_pkg::PIX_W];
            v_train = i_s_tdata[(c+NCH)*kbpc_pkg::PIX_W +: kbpc_pkg::PIX_W];
            v_diff  = (v_test >= v_train) ? (v_test - v_train) : (v_train - v_test);
            v_m     = kbpc_pkg::DIFF_MUL_W'(v_diff) * kbpc_pkg::DIFF_MUL_W'(i_inv_bw);
            n_u[c]  = kbpc_pkg::U_W'(v_m >> kbpc_pkg::DOWN_SHIFT)
                    + kbpc_pkg::U_W'(v_m[kbpc_pkg::DOWN_SHIFT-1]);
        end
    end

    // operand selection for the shared multiplier
    logic [kbpc_pkg::MUL_A_W-1:0] mul_a;
    logic [kbpc_pkg::MUL_B_W-1:0] mul_b;

    always_comb begin
        case (i_cmd.mul_op)
            kbpc_pkg::MOP_SQ0: begin
                mul_a = kbpc_pkg::MUL_A_W'(r_u[0]);
                mul_b = kbpc_pkg::MUL_B_W'(r_u[0]);
            end
            kbpc_pkg::MOP_SQ1: begin
                mul_a = kbpc_pkg::MUL_A_W'(r_u[1]);
                mul_b = kbpc_pkg::MUL_B_W'(r_u[1]);
            end
            kbpc_pkg::MOP_SQ2: begin
                mul_a = kbpc_pkg::MUL_A_W'(r_u[2]);
                mul_b = kbpc_pkg::MUL_B_W'(r_u[2]);
            end
            kbpc_pkg::MOP_EP01: begin
                mul_a = kbpc_pkg::MUL_A_W'(r_tmag[0]);
                mul_b = kbpc_pkg::MUL_B_W'(r_tmag[1]);
            end
            kbpc_pkg::MOP_EP2: begin
                mul_a = r_kmag;
                mul_b = kbpc_pkg::MUL_B_W'(r_tmag[2]);
            end
            kbpc_pkg::MOP_DENS: begin
                mul_a = r_kmag;
                mul_b = i_coef;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // one 24x32 partial product per cycle, low half first
    logic [kbpc_pkg::HALF_A_W-1:0] mul_half;
    logic [kbpc_pkg::PART_W-1:0]   mul_part;

    assign mul_half = i_cmd.mul_hi ? mul_a[kbpc_pkg::MUL_A_W-1:kbpc_pkg::HALF_A_W]
                                   : mul_a[kbpc_pkg::HALF_A_W-1:0];
    assign mul_part = kbpc_pkg::PART_W'(mul_half) * kbpc_pkg::PART_W'(mul_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_hi) begin
                r_prod <= r_prod + {mul_part, {kbpc_pkg::HALF_A_W{1'b0}}};
            end else begin
                r_prod <= kbpc_pkg::PROD_W'(mul_part);
            end
        end
    end

    // square rounded back to the fraction, and one minus it as sign and magnitude
    logic [kbpc_pkg::SQ_W-1:0] sq_p;
    logic [kbpc_pkg::T_W-1:0]  sq_r;
    logic [kbpc_pkg::T_W-1:0]  sq_tmag;
    logic                      sq_tneg;

    assign sq_p    = r_prod[kbpc_pkg::SQ_W-1:0];
    assign sq_r    = kbpc_pkg::T_W'(sq_p >> kbpc_pkg::FRAC_BITS)
                   + kbpc_pkg::T_W'(sq_p[kbpc_pkg::FRAC_BITS-1]);
    assign sq_tneg = (sq_r > kbpc_pkg::T_W'(kbpc_pkg::ONE_Q));
    assign sq_tmag = sq_tneg ? (sq_r - kbpc_pkg::T_W'(kbpc_pkg::ONE_Q))
                             : (kbpc_pkg::T_W'(kbpc_pkg::ONE_Q) - sq_r);

    // product shifted back, rounded and saturated on the magnitude
    logic [kbpc_pkg::PROD_W-1:0] fin_q;
    logic                        fin_rbit;
    logic                        fin_neg;
    logic [kbpc_pkg::ACC_W-1:0]  fin_lim;
    logic                        fin_big;
    logic [kbpc_pkg::ACC_W:0]    fin_inc;
    logic [kbpc_pkg::ACC_W-1:0]  fin_mag;
    logic [kbpc_pkg::ACC_W-1:0]  fin_val;

    always_comb begin
        case (i_cmd.commit)
            kbpc_pkg::CM_DENS: begin
                fin_q    = r_prod >> kbpc_pkg::COEF_SHIFT;
                fin_rbit = r_prod[kbpc_pkg::COEF_SHIFT-1];
                fin_neg  = r_kneg;
            end
            kbpc_pkg::CM_KER: begin
                fin_q    = r_prod >> kbpc_pkg::FRAC_BITS;
                fin_rbit = r_prod[kbpc_pkg::FRAC_BITS-1];
                fin_neg  = r_kneg ^ r_tneg[2];
            end
            default: begin
                fin_q    = r_prod >> kbpc_pkg::FRAC_BITS;
                fin_rbit = r_prod[kbpc_pkg::FRAC_BITS-1];
                fin_neg  = r_tneg[0] ^ r_tneg[1];
            end
        endcase
    end

    assign fin_lim = fin_neg ? kbpc_pkg::NEG_LIM : kbpc_pkg::POS_LIM;
    assign fin_big = |fin_q[kbpc_pkg::PROD_W-1:kbpc_pkg::ACC_W];
    assign fin_inc = {1'b0, fin_q[kbpc_pkg::ACC_W-1:0]} + (kbpc_pkg::ACC_W+1)'(fin_rbit);
    assign fin_mag = (fin_big || (fin_inc > {1'b0, fin_lim})) ? fin_lim
                                                              : fin_inc[kbpc_pkg::ACC_W-1:0];
    assign fin_val = fin_neg ? (~fin_mag + 1'b1) : fin_mag;

    // table lookup for the gaussian kernel
    logic                       g_hit;
    logic [kbpc_pkg::IDX_W-1:0] g_idx;
    logic [kbpc_pkg::ROM_W-1:0] g_ent;

    assign g_hit = ~|r_s[kbpc_pkg::S_W-1:kbpc_pkg::G_SHIFT+kbpc_pkg::IDX_W];
    assign g_idx = r_s[kbpc_pkg::G_SHIFT +: kbpc_pkg::IDX_W];
    assign g_ent = kbpc_pkg::EXP_ROM[g_idx];

    // saturating accumulate
    logic [kbpc_pkg::ACC_W:0]   acc_raw;
    logic [kbpc_pkg::ACC_W-1:0] acc_sat;

    assign acc_raw = {r_sum[kbpc_pkg::ACC_W-1], r_sum} + {r_kval[kbpc_pkg::ACC_W-1], r_kval};

    always_comb begin
        if (!acc_raw[kbpc_pkg::ACC_W] && acc_raw[kbpc_pkg::ACC_W-1]) begin
            acc_sat = kbpc_pkg::POS_LIM;
        end else if (acc_raw[kbpc_pkg::ACC_W] && !acc_raw[kbpc_pkg::ACC_W-1]) begin
            acc_sat = kbpc_pkg::NEG_LIM;
        end else begin
            acc_sat = acc_raw[kbpc_pkg::ACC_W-1:0];
        end
    end

    // request capture and intermediate results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int c = 0; c < NCH; c++) begin
                r_u[c] <= n_u[c];
            end
            r_last <= i_s_tlast;
            r_ksel <= i_ksel;
            r_s    <= '0;
        end
        case (i_cmd.commit)
            kbpc_pkg::CM_SQ0: begin
                r_tmag[0] <= sq_tmag;
                r_tneg[0] <= sq_tneg;
                r_s       <= r_s + kbpc_pkg::S_W'(sq_p);
            end
            kbpc_pkg::CM_SQ1: begin
                r_tmag[1] <= sq_tmag;
                r_tneg[1] <= sq_tneg;
                r_s       <= r_s + kbpc_pkg::S_W'(sq_p);
            end
            kbpc_pkg::CM_SQ2: begin
                r_tmag[2] <= sq_tmag;
                r_tneg[2] <= sq_tneg;
                r_s       <= r_s + kbpc_pkg::S_W'(sq_p);
            end
            kbpc_pkg::CM_K01: begin
                r_kmag <= fin_mag;
                r_kneg <= fin_neg;
            end
            kbpc_pkg::CM_KER: begin
                r_kval <= fin_val;
            end
            kbpc_pkg::CM_GAUSS: begin
                r_kval <= g_hit ? kbpc_pkg::ACC_W'(g_ent) : '0;
            end
            kbpc_pkg::CM_SABS: begin
                r_kmag <= r_sum[kbpc_pkg::ACC_W-1] ? (~r_sum + 1'b1) : r_sum;
                r_kneg <= r_sum[kbpc_pkg::ACC_W-1];
            end
            kbpc_pkg::CM_DENS: begin
                r_dens <= fin_val;
            end
            default: begin
                r_dens <= r_dens;
            end
        endcase
    end

    // kernel sum, cleared once its result is handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.out_load) begin
            r_sum <= '0;
        end else if (i_cmd.commit == kbpc_pkg::CM_ACC) begin
            r_sum <= acc_sat;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_density <= r_dens;
            r_out_fg      <= !($signed(r_dens) > i_thr);
        end
    end

    assign o_m_tvalid        = r_out_valid;
    assign o_m_density       = r_out_density;
    assign o_m_foreground    = r_out_fg;
    assign o_status.last     = r_last;
    assign o_status.ksel     = r_ksel;
    assign o_status.out_free = !r_out_valid || i_m_tready;

    // the sum restarts from zero after each result
    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_sum == '0))
        else $error("kernel sum not cleared after result");

    // the upper partial product always follows the lower one of the same pair
    a_hi_after_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_hi |-> ($past(i_cmd.mul_en && !i_cmd.mul_hi)
                          && $past(i_cmd.mul_op) == i_cmd.mul_op))
        else $error("upper partial product without matching lower half");

endmodule

// ===== rtl/core/kde_background_pixel_classifier.sv =====
// Top level of the KDE background pixel classifier: configuration registers,
// sequencer and datapath. Depends on kbpc_pkg, kbpc_ctrl and kbpc_dp.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata pixels, tlast last sample
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata density, tuser foreground
//  cfg       in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// From acceptance to the next ready, a request runs the three squares, then the
// table lookup in gaussian mode or two further products in epanechnikov mode, and
// the accumulate; a last sample adds the density product and waits for a free
// output register. The single shared 24x32 multiplier needs two passes per product
// and serves every square and product in turn. Reset is synchronous, active low, and
// loads the register defaults and clears the kernel sum. A result waiting in the
// output register does not stop new requests; only a further last sample waits for it.
`timescale 1ns / 1ps

module kde_background_pixel_classifier (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // test_red, test_green, test_blue, train_red, train_green, train_blue
    input  logic [47:0]                       s_axis_tdata,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // density
    output logic [47:0]                       m_axis_tdata,
    // foreground
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_we,
    input  logic [kbpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kbpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                              r_ksel;
    logic [kbpc_pkg::INV_W-1:0]        r_inv_bw;
    logic [kbpc_pkg::COEF_W-1:0]       r_coef;
    logic signed [kbpc_pkg::ACC_W-1:0] r_thr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksel   <= kbpc_pkg::KSEL_RST;
            r_inv_bw <= kbpc_pkg::INV_RST;
            r_coef   <= '0;
            r_thr    <= '0;
        end else if (i_cfg_we) begin
            case (kbpc_pkg::t_cfg_idx'(i_cfg_idx))
                kbpc_pkg::CFG_KERNEL_SELECT:       r_ksel   <= i_cfg_data[0];
                kbpc_pkg::CFG_INV_BANDWIDTH:       r_inv_bw <= i_cfg_data[kbpc_pkg::INV_W-1:0];
                kbpc_pkg::CFG_DENSITY_COEFFICIENT: r_coef   <= i_cfg_data[kbpc_pkg::COEF_W-1:0];
                kbpc_pkg::CFG_DENSITY_THRESHOLD:   r_thr    <= $signed(i_cfg_data);
                default:                           r_ksel   <= r_ksel;
            endcase
        end
    end

    kbpc_pkg::t_dp_cmd    w_cmd;
    kbpc_pkg::t_dp_status w_status;
    logic                 w_fg;

    // sequencer
    kbpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    kbpc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tlast      (s_axis_tlast),
        .i_ksel         (r_ksel),
        .i_inv_bw       (r_inv_bw),
        .i_coef         (r_coef),
        .i_thr          (r_thr),
        .i_m_tready     (m_axis_tready),
        .o_m_tvalid     (m_axis_tvalid),
        .o_m_density    (m_axis_tdata),
        .o_m_foreground (w_fg)
    );

    assign m_axis_tuser = w_fg;

endmodule
